// File: sv/postfix_stack_evaluator_defines.svh
// Assertion macros shared by the postfix stack evaluator RTL.
// No dependencies; files that assert include this header by name.
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define PSE_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("postfix_stack_evaluator: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("postfix_stack_evaluator: assertion failed");
`else
`define PSE_ASSERT(lbl, clk_s, rst_n_s, prop)
`define PSE_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)
`endif

`endif

// File: sv/pse_pkg.sv
// Types and constants for the postfix stack evaluator.
// No dependencies; used by the cell, the top level and the testbench.
`timescale 1ns / 1ps

package pse_pkg;

	localparam int STATUS_W = 3;
	localparam int OUT_VALUE_W = 16;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_TIMES = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} item_t;

	typedef struct packed {
		logic signed [OUT_VALUE_W-1:0] value;
		logic [STATUS_W-1:0]           status;
	} result_t;

	// Shift control for one stack cell.
	typedef struct packed {
		logic take_above;
		logic take_below;
	} cell_ctrl_t;

endpackage

// File: sv/pse_cell.sv
// One entry of the shifting operand stack.
// Depends on pse_pkg for the cell control struct.
`timescale 1ns / 1ps

module pse_cell #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                    clk,
	input  pse_pkg::cell_ctrl_t     ctrl,
	input  logic [VALUE_WIDTH-1:0]  above,
	input  logic [VALUE_WIDTH-1:0]  below,
	output logic [VALUE_WIDTH-1:0]  val
);

	logic [VALUE_WIDTH-1:0] val_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.take_above) begin
			val_q <= above;
		end else if (ctrl.take_below) begin
			val_q <= below;
		end else begin
			val_q <= val_q;
		end
	end

	assign val = val_q;

endmodule

// File: sv/pse_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// No package dependencies; instantiated by the top level.
`timescale 1ns / 1ps

module pse_divider #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient
);

	localparam int W = VALUE_WIDTH;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dsr_q;
	logic             neg_q;

	logic [W-1:0] a_abs;
	logic [W-1:0] b_abs;
	logic [W:0]   trial;
	logic         fit;
	logic [W-1:0] rem_n;
	logic [W-1:0] quo_n;

	// The magnitude of the most negative value still fits as unsigned.
	assign a_abs = dividend[W-1] ? W'(-dividend) : dividend;
	assign b_abs = divisor[W-1] ? W'(-divisor) : divisor;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};
	assign fit = !trial[W];
	assign rem_n = fit ? trial[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
	assign quo_n = {quo_q[W-2:0], fit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= a_abs;
			dsr_q <= b_abs;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? W'(-quo_q) : quo_q;

endmodule

// File: sv/postfix_stack_evaluator.sv
// Postfix expression evaluator built on a shifting stack of cells.
// Depends on pse_pkg, pse_cell, pse_divider and the assertion macro header.
//
// Usage: one ASCII character per input transaction on item_valid/item_stall/
// item_data; is_last marks the final character of an expression. Digits push,
// + - * / pop two operands and push the result; other characters are ignored.
// After the last character one result transaction (top of stack and status)
// leaves on result_valid/result_stall/result_data, and the stack is cleared.
// Steps: a digit, an ignored character, + or - is finished on acceptance; * is a
// registered multiply, then write back; / waits for the divider, which produces
// one quotient bit per cycle. An operator with fewer than two operands, and a
// division by zero, are finished on acceptance like +. After the last character
// the top of stack is moved into the output register in a separate emit step.
// item_stall is high while an item is being worked on.
// The output register holds a finished result while the receiver stalls; new
// characters are still taken, and only the next end of expression waits for
// the output register to empty. Reset clears the stack count, the error code
// and the output valid; stack cells are not cleared.
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_defines.svh"

module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = 16,
	parameter int VALUE_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  pse_pkg::item_t   item_data,
	output logic             result_valid,
	input  logic             result_stall,
	output pse_pkg::result_t result_data
);

	localparam int W = VALUE_WIDTH;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t                     state_q, state_d;
	logic [CW-1:0]              count_q, count_d;
	logic [pse_pkg::STATUS_W-1:0] err_q, err_d;
	logic                       last_q, last_d;
	logic [W-1:0]               prod_s1;
	logic                       result_valid_q;
	pse_pkg::result_t           result_q;

	logic [W-1:0]   cell_val [STACK_DEPTH];
	logic [W-1:0]   top_v;
	logic [W-1:0]   next_v;
	logic [2*W-1:0] prod_full;
	logic [W-1:0]   load_val;
	logic           push;
	logic           replace;
	logic           prod_load;
	logic           div_start;
	logic           div_done;
	logic [W-1:0]   div_quo;
	logic           out_load;
	logic           is_digit;
	logic           is_add;
	logic           is_sub;
	logic           is_mul;
	logic           is_div;
	logic           is_op;
	logic           can_push;
	logic           has_two;

	pse_pkg::cell_ctrl_t ctrl_top;
	pse_pkg::cell_ctrl_t ctrl_rest;

	assign top_v = cell_val[0];
	assign next_v = cell_val[1];

	assign is_digit = (item_data.char_code >= pse_pkg::CH_ZERO)
		&& (item_data.char_code <= pse_pkg::CH_NINE);
	assign is_add = item_data.char_code == pse_pkg::CH_PLUS;
	assign is_sub = item_data.char_code == pse_pkg::CH_MINUS;
	assign is_mul = item_data.char_code == pse_pkg::CH_TIMES;
	assign is_div = item_data.char_code == pse_pkg::CH_SLASH;
	assign is_op = is_add || is_sub || is_mul || is_div;

	assign can_push = count_q < CW'(STACK_DEPTH);
	assign has_two = count_q >= CW'(2);

	assign item_stall = (state_q != S_IDLE);

	// Only the low W bits of the product are kept; they do not depend on sign.
	assign prod_full = {{W{1'b0}}, top_v} * {{W{1'b0}}, next_v};

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		err_d = err_q;
		last_d = last_q;
		push = 1'b0;
		replace = 1'b0;
		load_val = '0;
		prod_load = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					last_d = item_data.is_last;
					state_d = item_data.is_last ? S_EMIT : S_IDLE;
					if (is_digit) begin
						if (can_push) begin
							push = 1'b1;
							load_val = W'(item_data.char_code[3:0]);
							count_d = count_q + CW'(1);
						end else if (err_q == pse_pkg::ST_OK) begin
							err_d = pse_pkg::ST_OVERFLOW;
						end
					end else if (is_op) begin
						if (!has_two) begin
							if (err_q == pse_pkg::ST_OK) begin
								err_d = pse_pkg::ST_UNDERFLOW;
							end
						end else begin
							priority if (is_add) begin
								replace = 1'b1;
								load_val = next_v + top_v;
								count_d = count_q - CW'(1);
							end else if (is_sub) begin
								replace = 1'b1;
								load_val = next_v - top_v;
								count_d = count_q - CW'(1);
							end else if (is_mul) begin
								prod_load = 1'b1;
								state_d = S_MUL;
							end else if (top_v == '0) begin
								// Division by zero leaves a zero in place of both operands.
								replace = 1'b1;
								load_val = '0;
								count_d = count_q - CW'(1);
								if (err_q == pse_pkg::ST_OK) begin
									err_d = pse_pkg::ST_DIVZERO;
								end
							end else begin
								div_start = 1'b1;
								state_d = S_DIV;
							end
						end
					end
				end
			end
			S_MUL: begin
				replace = 1'b1;
				load_val = prod_s1;
				count_d = count_q - CW'(1);
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_DIV: begin
				if (div_done) begin
					replace = 1'b1;
					load_val = div_quo;
					count_d = count_q - CW'(1);
					state_d = last_q ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					count_d = '0;
					err_d = pse_pkg::ST_OK;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// A push shifts every cell down; a replace pops one and overwrites the top.
	assign ctrl_top.take_above = push || replace;
	assign ctrl_top.take_below = 1'b0;
	assign ctrl_rest.take_above = push;
	assign ctrl_rest.take_below = replace;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_top
			pse_cell #(.VALUE_WIDTH(W)) u_cell (
				.clk   (clk),
				.ctrl  (ctrl_top),
				.above (load_val),
				.below (cell_val[1]),
				.val   (cell_val[0])
			);
		end else if (i == STACK_DEPTH - 1) begin : g_bottom
			pse_cell #(.VALUE_WIDTH(W)) u_cell (
				.clk   (clk),
				.ctrl  (ctrl_rest),
				.above (cell_val[i-1]),
				.below ({W{1'b0}}),
				.val   (cell_val[i])
			);
		end else begin : g_mid
			pse_cell #(.VALUE_WIDTH(W)) u_cell (
				.clk   (clk),
				.ctrl  (ctrl_rest),
				.above (cell_val[i-1]),
				.below (cell_val[i+1]),
				.val   (cell_val[i])
			);
		end
	end

	pse_divider #(.VALUE_WIDTH(W)) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (next_v),
		.divisor  (top_v),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			err_q <= pse_pkg::ST_OK;
			last_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q <= err_d;
			last_q <= last_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prod_load) begin
			prod_s1 <= prod_full[W-1:0];
		end
		if (out_load) begin
			result_q.value <= (count_q == '0) ? '0
				: pse_pkg::OUT_VALUE_W'($signed(top_v));
			if (err_q != pse_pkg::ST_OK) begin
				result_q.status <= err_q;
			end else if (count_q == '0) begin
				result_q.status <= pse_pkg::ST_EMPTY;
			end else begin
				result_q.status <= pse_pkg::ST_OK;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result_data = result_q;

	`PSE_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(STACK_DEPTH))
	`PSE_ASSERT(a_div_done_in_div, clk, arst_n, !div_done || (state_q == S_DIV))
	`PSE_ASSERT_NEXT(a_emit_clears, clk, arst_n, out_load, result_valid_q && (count_q == '0) && (err_q == pse_pkg::ST_OK))
	`PSE_ASSERT_NEXT(a_ignored_holds, clk, arst_n, (state_q == S_IDLE) && item_valid && !is_op && !is_digit && !item_data.is_last, $stable(count_q) && (state_q == S_IDLE))

endmodule

// File: verif/tb_postfix_stack_evaluator.sv
// Self-checking testbench for the postfix stack evaluator.
// Depends on pse_pkg and postfix_stack_evaluator; predicts every result internally.
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator;

	localparam int DEPTH       = 16;
	localparam int TARGET      = 1350;
	localparam int CALM_TAIL   = 150;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_WAIT  = 40;
	localparam int TIMEOUT_NS  = 4_000_000;

	typedef struct {
		pse_pkg::item_t payload;
		bit             drain_first;
	} char_entry_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	pse_pkg::item_t   item_data = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	pse_pkg::result_t result_data;

	char_entry_t      char_queue[$];
	pse_pkg::result_t pending_results[$];

	// Predicted evaluator state.
	logic signed [15:0] operands [DEPTH];
	int                 operand_count = 0;
	logic [2:0]         first_error = pse_pkg::ST_OK;

	int  token_count = 0;
	int  sent_count = 0;
	int  accepted_items = 0;
	int  mismatches = 0;
	int  send_gap = 0;
	int  stall_gap = 0;
	bit  item_taken = 1'b0;
	bit  long_hold = 1'b0;

	postfix_stack_evaluator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	always #5 clk = ~clk;

	function automatic bit is_token(input logic [7:0] c);
		return (c >= pse_pkg::CH_ZERO && c <= pse_pkg::CH_NINE) || c == pse_pkg::CH_PLUS ||
			c == pse_pkg::CH_MINUS || c == pse_pkg::CH_TIMES || c == pse_pkg::CH_SLASH;
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 3))
			0: return pse_pkg::CH_PLUS;
			1: return pse_pkg::CH_MINUS;
			2: return pse_pkg::CH_TIMES;
			default: return pse_pkg::CH_SLASH;
		endcase
	endfunction

	function automatic logic [7:0] pick_other();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_token(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// No idling near the end of the run, and in regular quiet stretches.
	function automatic bit quiet_phase();
		return char_queue.size() < CALM_TAIL || (sent_count % 400) >= 320;
	endfunction

	task automatic add_char(input logic [7:0] c, input bit last);
		char_entry_t e;
		e.payload.char_code = c;
		e.payload.is_last = last;
		e.drain_first = 1'b0;
		char_queue.push_back(e);
		if (is_token(c))
			token_count++;
	endtask

	task automatic add_string(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], i == s.len() - 1);
	endtask

	// Mostly well-formed expressions with random digits and operators, plus
	// stack-filling runs, stray characters and broken sequences.
	task automatic add_expression(input bit force_drain);
		int first_idx;
		int mode;
		int digits;
		int ops;
		int level;
		first_idx = char_queue.size();
		mode = $urandom_range(0, 19);
		if (mode == 0) begin
			for (int i = $urandom_range(1, 8); i > 0; i--) begin
				case ($urandom_range(0, 2))
					0: add_char(8'(pse_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
					1: add_char(pick_operator(), 1'b0);
					default: add_char(pick_other(), 1'b0);
				endcase
			end
		end else begin
			digits = (mode == 1) ? $urandom_range(17, 20) : $urandom_range(1, 9);
			ops = digits - 1;
			level = 0;
			while (digits + ops > 0) begin
				if ($urandom_range(0, 15) == 0)
					add_char(pick_other(), 1'b0);
				if (digits > 0 && (mode == 1 || level < 2 || $urandom_range(0, 1))) begin
					add_char(8'(pse_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
					digits--;
					level++;
				end else begin
					add_char(pick_operator(), 1'b0);
					ops--;
					level--;
				end
			end
			if (mode == 2)
				add_char(pick_other(), 1'b0);
		end
		char_queue[$].payload.is_last = 1'b1;
		if (force_drain || $urandom_range(0, 29) == 0)
			char_queue[first_idx].drain_first = 1'b1;
	endtask

	task automatic note_error(input logic [2:0] code);
		if (first_error == pse_pkg::ST_OK)
			first_error = code;
	endtask

	task automatic push_operand(input logic signed [15:0] v);
		if (operand_count >= DEPTH) begin
			note_error(pse_pkg::ST_OVERFLOW);
		end else begin
			operands[operand_count] = v;
			operand_count++;
		end
	endtask

	task automatic eval_char(input pse_pkg::item_t it);
		logic signed [15:0] rhs;
		logic signed [15:0] lhs;
		logic signed [15:0] res;
		pse_pkg::result_t r;
		case (it.char_code)
			pse_pkg::CH_PLUS, pse_pkg::CH_MINUS, pse_pkg::CH_TIMES, pse_pkg::CH_SLASH: begin
				if (operand_count < 2) begin
					note_error(pse_pkg::ST_UNDERFLOW);
				end else begin
					rhs = operands[operand_count - 1];
					lhs = operands[operand_count - 2];
					operand_count -= 2;
					case (it.char_code)
						pse_pkg::CH_PLUS: res = lhs + rhs;
						pse_pkg::CH_MINUS: res = lhs - rhs;
						pse_pkg::CH_TIMES: res = lhs * rhs;
						default: begin
							if (rhs == 0) begin
								note_error(pse_pkg::ST_DIVZERO);
								res = '0;
							end else begin
								// Wider quotient so that the most negative over -1 wraps.
								res = 16'(int'(lhs) / int'(rhs));
							end
						end
					endcase
					push_operand(res);
				end
			end
			default: begin
				if (it.char_code >= pse_pkg::CH_ZERO && it.char_code <= pse_pkg::CH_NINE)
					push_operand(16'(it.char_code - pse_pkg::CH_ZERO));
			end
		endcase
		if (it.is_last) begin
			r.value = (operand_count > 0) ? operands[operand_count - 1] : '0;
			if (first_error != pse_pkg::ST_OK)
				r.status = first_error;
			else
				r.status = (operand_count > 0) ? pse_pkg::ST_OK : pse_pkg::ST_EMPTY;
			pending_results.push_back(r);
			operand_count = 0;
			first_error = pse_pkg::ST_OK;
		end
	endtask

	// Sender: a new transaction is offered only once the previous one is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (send_gap > 0) begin
					item_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (char_queue.size() == 0) begin
					item_valid <= 1'b0;
				end else if (char_queue[0].drain_first && pending_results.size() != 0) begin
					item_valid <= 1'b0;
				end else if (!quiet_phase() && $urandom_range(0, 9) == 0) begin
					item_valid <= 1'b0;
					send_gap <= $urandom_range(0, 15);
				end else begin
					item_data <= char_queue[0].payload;
					item_valid <= 1'b1;
					void'(char_queue.pop_front());
					sent_count <= sent_count + 1;
				end
			end
		end
	end

	// Receiver stall: random bursts, plus the long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_gap > 0) begin
				stall_gap <= stall_gap - 1;
				result_stall <= 1'b1;
			end else if (!quiet_phase() && $urandom_range(0, 9) == 0) begin
				stall_gap <= $urandom_range(0, 15);
				result_stall <= 1'b1;
			end else begin
				result_stall <= long_hold;
			end
		end
	end

	always @(posedge clk) begin
		pse_pkg::result_t want;
		if (arst_n) begin
			item_taken <= item_valid && !item_stall;
			if (item_valid && !item_stall) begin
				eval_char(item_data);
				accepted_items++;
			end
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result value %0d status %0d", $time,
						result_data.value, result_data.status);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (result_data.value !== want.value) begin
						$display("%0t: value expected %0d got %0d", $time, want.value,
							result_data.value);
						mismatches++;
					end
					if (result_data.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status,
							result_data.status);
						mismatches++;
					end
				end
			end
		end
	end

	// Long receiver hold-off so that a finished result blocks the next one.
	initial begin
		while (accepted_items < 400)
			@(posedge clk);
		long_hold = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		long_hold = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		add_char(8'h00, 1'b0);
		add_char(8'hFF, 1'b1);
		add_string("7+");
		add_string("93-2*4/");
		add_string("50/");
		add_string("88*8*8*8*01-/");
		add_expression(1'b1);
		while (token_count < TARGET)
			add_expression(1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_queue.size() != 0 || item_valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/pse_pkg.sv
sv/pse_cell.sv
sv/pse_divider.sv
sv/postfix_stack_evaluator.sv
verif/tb_postfix_stack_evaluator.sv
